// ===== rtl/core/rrv_pkg.sv =====
`timescale 1ns / 1ps

package rrv_pkg;

    localparam int RADIUS_W       = 14;
    localparam int RAD_W          = 2 * RADIUS_W;
    localparam int SQRT_STEPS     = RADIUS_W;
    localparam int COORD_W        = 19;
    localparam int INDEX_W        = 6;
    localparam int PPC_W          = 5;
    localparam int MAX_POINTS_DEF = 16;
    localparam logic [PPC_W-1:0] PPC_RESET = 5'd8;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef enum logic [1:0] {
        CORNER_TR = 2'd0,
        CORNER_BR = 2'd1,
        CORNER_BL = 2'd2,
        CORNER_TL = 2'd3
    } corner_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV,
        ST_MUL,
        ST_SQRT,
        ST_PUT
    } state_t;

    typedef struct packed {
        logic signed [15:0]  pos_x;
        logic signed [15:0]  pos_y;
        logic [14:0]         rect_width;
        logic [14:0]         rect_height;
        logic [RADIUS_W-1:0] corner_radius;
        logic [3:0]          corner_mask;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] vertex_x;
        logic signed [15:0] vertex_y;
        logic [INDEX_W-1:0] vertex_index;
        logic               last_vertex;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic div_init;
        logic div_step;
        logic sqrt_init;
        logic sqrt_step;
        logic put;
        logic adv_k;
        logic adv_corner;
    } cmd_t;

    typedef struct packed {
        logic round;
        logic arc_end;
        logic last_corner;
        logic out_free;
    } status_t;

    function automatic logic signed [15:0] sat_coord(input coord_t v);
        logic signed [15:0] res;
        if (v > coord_t'(32767)) begin
            res = 16'sh7FFF;
        end else if (v < -coord_t'(32768)) begin
            res = -16'sh8000;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/rrv_ctrl.sv =====
`timescale 1ns / 1ps

module rrv_ctrl #(
    parameter int MAX_POINTS = rrv_pkg::MAX_POINTS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  rrv_pkg::status_t status,
    output rrv_pkg::cmd_t    cmd
);

    localparam int KW        = $clog2(MAX_POINTS + 1);
    localparam int DIV_STEPS = rrv_pkg::RADIUS_W + KW;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    rrv_pkg::state_t    state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rrv_pkg::ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            rrv_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = rrv_pkg::ST_SETUP;
                end
            end
            rrv_pkg::ST_SETUP: begin
                step_next = '0;
                if (status.round) begin
                    cmd.div_init = 1'b1;
                    state_next   = rrv_pkg::ST_DIV;
                end else begin
                    state_next = rrv_pkg::ST_PUT;
                end
            end
            rrv_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                    state_next = rrv_pkg::ST_MUL;
                end
            end
            rrv_pkg::ST_MUL: begin
                cmd.sqrt_init = 1'b1;
                step_next     = '0;
                state_next    = rrv_pkg::ST_SQRT;
            end
            rrv_pkg::ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                step_next     = step_reg + 1'b1;
                if (step_reg == STEP_W'(rrv_pkg::SQRT_STEPS - 1)) begin
                    state_next = rrv_pkg::ST_PUT;
                end
            end
            rrv_pkg::ST_PUT: begin
                // hold until the output register can take the vertex
                if (status.out_free) begin
                    cmd.put = 1'b1;
                    if (status.round && !status.arc_end) begin
                        cmd.adv_k  = 1'b1;
                        state_next = rrv_pkg::ST_SETUP;
                    end else if (!status.last_corner) begin
                        cmd.adv_corner = 1'b1;
                        state_next     = rrv_pkg::ST_SETUP;
                    end else begin
                        state_next = rrv_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = rrv_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/rrv_datapath.sv =====
`timescale 1ns / 1ps

module rrv_datapath #(
    parameter int MAX_POINTS = rrv_pkg::MAX_POINTS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [rrv_pkg::PPC_W-1:0] cfg_wdata,
    input  rrv_pkg::in_item_t         s_data,
    input  rrv_pkg::cmd_t             cmd,
    output rrv_pkg::status_t          status,
    output logic                      m_valid,
    input  logic                      m_ready,
    output rrv_pkg::out_item_t        m_data
);

    localparam int KW    = $clog2(MAX_POINTS + 1);
    localparam int NUM_W = rrv_pkg::RADIUS_W + KW;
    localparam int RW    = rrv_pkg::RADIUS_W;
    localparam int QW    = rrv_pkg::RAD_W;
    localparam int IW    = rrv_pkg::INDEX_W;

    // configuration
    logic [rrv_pkg::PPC_W-1:0] ppc_reg;
    logic [KW-1:0]             p_eff;

    // command
    rrv_pkg::coord_t px_reg, py_reg, pw_reg, ph_reg;
    rrv_pkg::coord_t pwr_reg, prr_reg, pyr_reg, phr_reg;
    logic [RW-1:0]   r_reg;
    logic [QW-1:0]   rsq_reg;
    logic [3:0]      mask_reg;
    logic [KW-1:0]   p_reg;
    logic [KW-1:0]   k_reg;
    rrv_pkg::corner_t corner_reg;
    logic [IW-1:0]   index_reg;

    // divider and square root
    logic [NUM_W-1:0] num_reg;
    logic [KW-1:0]    rem_reg;
    logic [KW:0]      div_trial;
    logic             div_ge;
    logic [RW-1:0]    a_val;
    logic [QW-1:0]    rad_reg;
    logic [QW-1:0]    res_reg;
    logic [QW-1:0]    bit_reg;
    logic [QW-1:0]    sq_trial;
    logic             sq_ge;

    // vertex
    rrv_pkg::coord_t px_in, py_in, w_in, h_in, r_in;
    rrv_pkg::coord_t a_c, b_c, x_c, y_c;
    logic            round_now;
    logic            m_valid_reg;
    rrv_pkg::out_item_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ppc_reg <= rrv_pkg::PPC_RESET;
        end else if (cfg_we) begin
            ppc_reg <= cfg_wdata;
        end
    end

    always_comb begin
        if (ppc_reg == '0) begin
            p_eff = KW'(1);
        end else if (ppc_reg > rrv_pkg::PPC_W'(MAX_POINTS)) begin
            p_eff = KW'(MAX_POINTS);
        end else begin
            p_eff = KW'(ppc_reg);
        end
    end

    assign px_in = rrv_pkg::coord_t'(s_data.pos_x);
    assign py_in = rrv_pkg::coord_t'(s_data.pos_y);
    assign w_in  = rrv_pkg::coord_t'(s_data.rect_width);
    assign h_in  = rrv_pkg::coord_t'(s_data.rect_height);
    assign r_in  = rrv_pkg::coord_t'(s_data.corner_radius);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            px_reg     <= px_in;
            py_reg     <= py_in;
            pw_reg     <= px_in + w_in;
            ph_reg     <= py_in + h_in;
            pwr_reg    <= px_in + w_in - r_in;
            prr_reg    <= px_in + r_in;
            pyr_reg    <= py_in + r_in;
            phr_reg    <= py_in + h_in - r_in;
            r_reg      <= s_data.corner_radius;
            rsq_reg    <= QW'(s_data.corner_radius) * QW'(s_data.corner_radius);
            mask_reg   <= s_data.corner_mask;
            p_reg      <= p_eff;
            k_reg      <= KW'(1);
            corner_reg <= rrv_pkg::CORNER_TR;
            index_reg  <= '0;
        end else begin
            if (cmd.adv_k) begin
                k_reg <= k_reg + 1'b1;
            end
            if (cmd.adv_corner) begin
                k_reg      <= KW'(1);
                corner_reg <= rrv_pkg::corner_t'(corner_reg + 2'd1);
            end
            if (cmd.put) begin
                index_reg <= index_reg + 1'b1;
            end
        end
    end

    // restoring division of r*k by p, one quotient bit per cycle;
    // the quotient shifts into num_reg as the numerator shifts out
    assign div_trial = {rem_reg, num_reg[NUM_W-1]};
    assign div_ge    = div_trial >= {1'b0, p_reg};
    assign a_val     = num_reg[RW-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            num_reg <= NUM_W'(r_reg) * NUM_W'(k_reg);
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            num_reg <= {num_reg[NUM_W-2:0], div_ge};
            rem_reg <= div_ge ? KW'(div_trial - {1'b0, p_reg}) : div_trial[KW-1:0];
        end
    end

    // integer square root of r*r - a*a, one result bit per cycle
    assign sq_trial = res_reg + bit_reg;
    assign sq_ge    = rad_reg >= sq_trial;

    always_ff @(posedge aclk) begin
        if (cmd.sqrt_init) begin
            rad_reg <= rsq_reg - QW'(a_val) * QW'(a_val);
            res_reg <= '0;
            bit_reg <= QW'(1) << (QW - 2);
        end else if (cmd.sqrt_step) begin
            if (sq_ge) begin
                rad_reg <= rad_reg - sq_trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    // mask bits run top-left first, corners run top-right first
    assign round_now = mask_reg[2'(corner_reg + 2'd1)];
    assign a_c       = rrv_pkg::coord_t'(a_val);
    assign b_c       = rrv_pkg::coord_t'(res_reg[RW-1:0]);

    always_comb begin
        unique case (corner_reg)
            rrv_pkg::CORNER_TR: begin
                x_c = round_now ? pwr_reg + a_c : pw_reg;
                y_c = round_now ? pyr_reg - b_c : py_reg;
            end
            rrv_pkg::CORNER_BR: begin
                x_c = round_now ? pwr_reg + b_c : pw_reg;
                y_c = round_now ? phr_reg + a_c : ph_reg;
            end
            rrv_pkg::CORNER_BL: begin
                x_c = round_now ? prr_reg - a_c : px_reg;
                y_c = round_now ? phr_reg + b_c : ph_reg;
            end
            rrv_pkg::CORNER_TL: begin
                x_c = round_now ? prr_reg - b_c : px_reg;
                y_c = round_now ? pyr_reg - a_c : py_reg;
            end
            default: begin
                x_c = px_reg;
                y_c = py_reg;
            end
        endcase
    end

    assign status.round       = round_now;
    assign status.arc_end     = k_reg == p_reg;
    assign status.last_corner = corner_reg == rrv_pkg::CORNER_TL;
    assign status.out_free    = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.put) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.put) begin
            m_data_reg.vertex_x     <= rrv_pkg::sat_coord(x_c);
            m_data_reg.vertex_y     <= rrv_pkg::sat_coord(y_c);
            m_data_reg.vertex_index <= index_reg;
            m_data_reg.last_vertex  <= (corner_reg == rrv_pkg::CORNER_TL)
                                       && (!round_now || (k_reg == p_reg));
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/core/rounded_rect_vertex_generator_core.sv =====
// Each request is taken in the idle state; every vertex then passes the setup state. A square
// corner vertex goes straight to the put state, a rounded one through the serial divider, the
// multiply state and the serial square root first; put registers it once the output is free.
// No new request is taken until the last vertex of the current one has been put.
// Reset (aresetn, synchronous, active low) clears the controller, the output valid
// and sets points_per_corner to 8.
`timescale 1ns / 1ps

module rounded_rect_vertex_generator_core #(
    parameter int MAX_POINTS = rrv_pkg::MAX_POINTS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [rrv_pkg::PPC_W-1:0] cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  rrv_pkg::in_item_t         s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output rrv_pkg::out_item_t        m_data
);

    rrv_pkg::cmd_t    cmd;
    rrv_pkg::status_t status;

    rrv_ctrl #(
        .MAX_POINTS(MAX_POINTS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    rrv_datapath #(
        .MAX_POINTS(MAX_POINTS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ===== sim/rrv_checker.sv =====
`timescale 1ns / 1ps

module rrv_checker
    import rrv_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [PPC_W-1:0] cfg_wdata,
    input  logic             s_valid,
    input  logic             s_ready,
    input  in_item_t         s_data,
    input  logic             m_valid,
    input  logic             m_ready,
    input  out_item_t        m_data,
    output int               open_vertices,
    output int               vertex_errors
);

    localparam int MAX_PTS = MAX_POINTS_DEF;

    out_item_t        vertex_q[$];
    logic [PPC_W-1:0] arc_points;
    int               err_n = 0;

    // floor of the square root, one result bit at a time from the top
    function automatic longint root_floor(input longint n);
        longint res;
        longint trial;
        res = 0;
        for (int bt = 15; bt >= 0; bt--) begin
            trial = res | (longint'(1) << bt);
            if (trial * trial <= n) begin
                res = trial;
            end
        end
        return res;
    endfunction

    function automatic logic signed [15:0] clip16(input longint v);
        logic signed [15:0] res;
        if (v > 32767) begin
            res = 16'sh7FFF;
        end else if (v < -32768) begin
            res = 16'sh8000;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

    task automatic trace_outline(input in_item_t rect);
        longint    px;
        longint    py;
        longint    w;
        longint    h;
        longint    r;
        longint    a;
        longint    b;
        longint    steps;
        longint    vx;
        longint    vy;
        int        total;
        int        idx;
        int        n;
        bit        round;
        corner_t   cn;
        out_item_t v;
        px = $signed(rect.pos_x);
        py = $signed(rect.pos_y);
        w = rect.rect_width;
        h = rect.rect_height;
        r = rect.corner_radius;
        steps = arc_points;
        if (steps < 1) begin
            steps = 1;
        end
        if (steps > MAX_PTS) begin
            steps = MAX_PTS;
        end
        total = 0;
        for (int c = 0; c < 4; c++) begin
            total += rect.corner_mask[(c + 1) % 4] ? int'(steps) : 1;
        end
        idx = 0;
        // walk clockwise from top-right; mask bit for corner c is (c+1) mod 4
        for (int c = 0; c < 4; c++) begin
            cn = corner_t'(c);
            round = rect.corner_mask[(c + 1) % 4];
            n = round ? int'(steps) : 1;
            for (int k = 1; k <= n; k++) begin
                if (round) begin
                    a = (r * k) / steps;
                    b = root_floor(r * r - a * a);
                    case (cn)
                        CORNER_TR: begin
                            vx = px + w - r + a;
                            vy = py + r - b;
                        end
                        CORNER_BR: begin
                            vx = px + w - r + b;
                            vy = py + h - r + a;
                        end
                        CORNER_BL: begin
                            vx = px + r - a;
                            vy = py + h - r + b;
                        end
                        default: begin
                            vx = px + r - b;
                            vy = py + r - a;
                        end
                    endcase
                end else begin
                    case (cn)
                        CORNER_TR: begin
                            vx = px + w;
                            vy = py;
                        end
                        CORNER_BR: begin
                            vx = px + w;
                            vy = py + h;
                        end
                        CORNER_BL: begin
                            vx = px;
                            vy = py + h;
                        end
                        default: begin
                            vx = px;
                            vy = py;
                        end
                    endcase
                end
                v.vertex_x = clip16(vx);
                v.vertex_y = clip16(vy);
                v.vertex_index = idx[INDEX_W-1:0];
                v.last_vertex = (idx == total - 1);
                vertex_q.push_back(v);
                idx++;
            end
        end
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            vertex_q.delete();
            arc_points = PPC_RESET;
        end else begin
            if (cfg_we) begin
                arc_points = cfg_wdata;
            end
            // check outputs before queuing the new request's vertices
            if (m_valid && m_ready) begin
                if (vertex_q.size() == 0) begin
                    err_n++;
                    if (err_n <= 10) begin
                        $display("%0t: unexpected vertex x=%0d y=%0d idx=%0d last=%0b", $time,
                                 m_data.vertex_x, m_data.vertex_y, m_data.vertex_index,
                                 m_data.last_vertex);
                    end
                end else begin
                    want = vertex_q.pop_front();
                    if (m_data.vertex_x !== want.vertex_x || m_data.vertex_y !== want.vertex_y ||
                        m_data.vertex_index !== want.vertex_index ||
                        m_data.last_vertex !== want.last_vertex) begin
                        err_n++;
                        if (err_n <= 10) begin
                            $display("%0t: vertex mismatch exp x=%0d y=%0d idx=%0d last=%0b",
                                     $time, want.vertex_x, want.vertex_y, want.vertex_index,
                                     want.last_vertex);
                            $display("%0t:                 got x=%0d y=%0d idx=%0d last=%0b",
                                     $time, m_data.vertex_x, m_data.vertex_y,
                                     m_data.vertex_index, m_data.last_vertex);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                trace_outline(s_data);
            end
        end
        open_vertices <= vertex_q.size();
        vertex_errors <= err_n;
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import rrv_pkg::*;

    localparam int PHASES = 10;
    localparam int RECTS_PER_PHASE = 45;

    logic             aclk;
    logic             aresetn;
    logic             cfg_we;
    logic [PPC_W-1:0] cfg_wdata;
    logic             s_valid;
    logic             s_ready;
    in_item_t         s_data;
    logic             m_valid;
    logic             m_ready;
    out_item_t        m_data;
    int               open_vertices;
    int               vertex_errors;
    bit               quiet = 1'b0;

    rounded_rect_vertex_generator_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    rrv_checker outline_chk (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .open_vertices(open_vertices),
        .vertex_errors(vertex_errors)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // result side: stall a random number of cycles before each vertex, except in quiet phases
    initial begin
        int stall;
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    function automatic in_item_t rect_of(input int px, input int py, input int w, input int h,
                                         input int r, input int mask);
        in_item_t rect;
        rect.pos_x = 16'(px);
        rect.pos_y = 16'(py);
        rect.rect_width = 15'(w);
        rect.rect_height = 15'(h);
        rect.corner_radius = 14'(r);
        rect.corner_mask = 4'(mask);
        return rect;
    endfunction

    function automatic in_item_t random_rect();
        in_item_t rect;
        int w;
        int h;
        int span;
        case ($urandom_range(0, 9))
            0, 1: begin
                rect.pos_x = 16'($urandom);
                rect.pos_y = 16'($urandom);
                rect.rect_width = 15'($urandom);
                rect.rect_height = 15'($urandom);
                rect.corner_radius = 14'($urandom);
                rect.corner_mask = 4'($urandom);
            end
            2: begin
                // park near the edges of the coordinate range to hit saturation
                rect.pos_x = 16'($urandom_range(0, 1) ? 32767 - int'($urandom_range(0, 3000))
                                                       : -32768 + int'($urandom_range(0, 3000)));
                rect.pos_y = 16'($urandom_range(0, 1) ? 32767 - int'($urandom_range(0, 3000))
                                                       : -32768 + int'($urandom_range(0, 3000)));
                rect.rect_width = 15'($urandom_range(0, 32767));
                rect.rect_height = 15'($urandom_range(0, 32767));
                rect.corner_radius = 14'($urandom_range(0, 16383));
                rect.corner_mask = 4'($urandom);
            end
            default: begin
                w = $urandom_range(0, 4000);
                h = $urandom_range(0, 4000);
                span = (w < h ? w : h) / 2;
                rect.pos_x = 16'(int'($urandom_range(0, 8191)) - 4096);
                rect.pos_y = 16'(int'($urandom_range(0, 8191)) - 4096);
                rect.rect_width = 15'(w);
                rect.rect_height = 15'(h);
                rect.corner_radius = 14'($urandom_range(0, span));
                rect.corner_mask = 4'($urandom);
            end
        endcase
        return rect;
    endfunction

    task automatic send_rect(input in_item_t rect);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_data <= rect;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // hold off new requests until every predicted vertex has come back
    task automatic drain_vertices();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (open_vertices != 0) @(posedge aclk);
    endtask

    initial begin
        logic [PPC_W-1:0] ppc_plan [PHASES];
        aresetn <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        s_valid <= 1'b0;
        s_data <= '0;
        ppc_plan = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd3, 5'd12, 5'd2, 5'd5, 5'd8};
        ppc_plan[8] = 5'($urandom_range(0, 31));
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed shapes at the reset arc count
        send_rect(rect_of(0, 0, 0, 0, 0, 0));
        send_rect(rect_of(0, 0, 0, 0, 0, 15));
        send_rect(rect_of(160, 320, 800, 480, 64, 15));
        send_rect(rect_of(-160, 96, 640, 320, 80, 1));
        send_rect(rect_of(-160, 96, 640, 320, 80, 2));
        send_rect(rect_of(-160, 96, 640, 320, 80, 4));
        send_rect(rect_of(-160, 96, 640, 320, 80, 8));
        send_rect(rect_of(-500, -700, 1200, 900, 300, 5));
        send_rect(rect_of(-500, -700, 1200, 900, 300, 10));
        send_rect(rect_of(-32768, -32768, 32767, 32767, 16383, 15));
        send_rect(rect_of(32767, 32767, 32767, 32767, 0, 0));
        send_rect(rect_of(32767, 32767, 32767, 32767, 16383, 15));
        send_rect(rect_of(-32768, -32768, 0, 0, 16383, 15));
        send_rect(rect_of(1000, 1000, 16, 16, 16383, 15));
        send_rect(rect_of(0, 0, 32, 32, 1, 15));
        send_rect(rect_of(0, 0, 32767, 32767, 16383, 6));

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_vertices();
            quiet <= (ph % 3 == 2);
            cfg_we <= 1'b1;
            cfg_wdata <= ppc_plan[ph];
            @(posedge aclk);
            cfg_we <= 1'b0;
            for (int i = 0; i < RECTS_PER_PHASE; i++) begin
                send_rect(random_rect());
            end
        end

        drain_vertices();
        repeat (64) @(posedge aclk);
        if (vertex_errors == 0 && open_vertices == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
